@@ rtl/gbfs_pkg.sv @@
// Package for the grid best-first path search block.
// Holds the transfer structs, the controller state type, direction codes and defaults.
// Depends on nothing; grid_best_first_path_search and the bench use it by scoped names.
package gbfs_pkg;

  localparam int unsigned GridWMaxDefault = 16;
  localparam int unsigned GridHMaxDefault = 16;
  localparam int unsigned MaxPathDefault  = 64;

  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgAddrW-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CfgAddrW-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [CfgDataW-1:0] GridWidthReset  = 5'd16;
  localparam logic [CfgDataW-1:0] GridHeightReset = 5'd16;

  typedef struct packed {
    logic [3:0] start_x;
    logic [3:0] start_y;
    logic [3:0] goal_x;
    logic [3:0] goal_y;
  } query_t;

  typedef struct packed {
    logic [3:0] tile_x;
    logic [3:0] tile_y;
    logic       found;
    logic       last_tile;
  } result_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_POP,
    S_POP_WAIT,
    S_SD_RD,
    S_SD_CMP,
    S_EXP_RD,
    S_EXP_CHK,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_WALK_EMIT,
    S_WALK_STEP
  } state_e;

endpackage

@@ rtl/gbfs_heap_ram.sv @@
// Frontier heap storage: one write port and two registered read ports.
// Uses no package items; instantiated by grid_best_first_path_search.
module gbfs_heap_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [DW-1:0] rdata0_o,
  output logic [DW-1:0] rdata1_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

@@ rtl/gbfs_tile_ram.sv @@
// Per-tile storage of the visited mark and parent direction, one registered read port.
// Uses no package items; instantiated by grid_best_first_path_search.
module gbfs_tile_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/grid_best_first_path_search.sv @@
// A query first clears the tile memory over all 2**(clog2(GRID_W_MAX)+clog2(GRID_H_MAX)) addresses
// (256 by default) and then sets up the start tile. After that it pops the frontier, sifts the heap
// down level by level, checks each neighbour on the grid, pushes each undiscovered one and lets it
// climb the heap level by level, and once the goal is found sends the path tile by tile.
// The memories have registered reads, which puts a read state before every compare.
// Off-grid and start-equals-goal queries give their one result in the cycle after start. Results
// are one-cycle strobes that cannot be held off; busy stays high until the last one has been issued.
module grid_best_first_path_search #(
  parameter int unsigned GRID_W_MAX = gbfs_pkg::GridWMaxDefault,
  parameter int unsigned GRID_H_MAX = gbfs_pkg::GridHMaxDefault,
  parameter int unsigned MAX_PATH   = gbfs_pkg::MaxPathDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  gbfs_pkg::query_t              query_i,
  output logic                          result_valid_o,
  output gbfs_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [gbfs_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [gbfs_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned CW     = $clog2(GRID_W_MAX);
  localparam int unsigned CH     = $clog2(GRID_H_MAX);
  localparam int unsigned TAW    = CW + CH;
  localparam int unsigned NTILES = GRID_W_MAX * GRID_H_MAX;
  localparam int unsigned HAW    = $clog2(NTILES);
  localparam int unsigned CNTW   = HAW + 1;
  localparam int unsigned SW     = $clog2(NTILES + 1);
  localparam int unsigned MW     = (CW > CH) ? ((CW > 4) ? CW : 4) : ((CH > 4) ? CH : 4);
  localparam int unsigned DW     = 2 * MW + 1;
  localparam int unsigned EW     = DW + SW + TAW;
  localparam int unsigned PW     = $clog2(MAX_PATH + 1);
  localparam logic [7:0]  WMax8  = 8'(GRID_W_MAX);
  localparam logic [7:0]  HMax8  = 8'(GRID_H_MAX);

  gbfs_pkg::state_e  state_q, state_d;
  gbfs_pkg::dir_e    dir_q, dir_d;
  gbfs_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [gbfs_pkg::CfgDataW-1:0] gw_q, gh_q;
  logic [CW-1:0]   sx_q, sx_d, gx_q, gx_d, cx_q, cx_d;
  logic [CH-1:0]   sy_q, sy_d, gy_q, gy_d, cy_q, cy_d;
  logic [TAW-1:0]  clr_q, clr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   seq_q, seq_d;
  logic [HAW-1:0]  idx_q, idx_d;
  logic [EW-1:0]   pend_q, pend_d;
  logic [PW-1:0]   n_q, n_d;

  logic          h_we;
  logic [HAW-1:0] h_waddr, h_ra0, h_ra1;
  logic [EW-1:0] h_wdata, h_rd0, h_rd1;
  logic          t_we;
  logic [TAW-1:0] t_waddr, t_ra;
  logic [2:0]    t_wdata, t_rd;

  logic [7:0] wc, hc, qsx8, qsy8, qgx8, qgy8, cx8, cy8, nx8, ny8, gx8, gy8;
  logic       q_off, q_same, inb, n_goal, at_start, path_end, last_dir;
  logic [TAW-1:0] naddr, caddr;
  logic signed [8:0]  ddx, ddy;
  logic signed [17:0] sqx, sqy;
  logic [18:0]        dsum;
  logic [HAW+1:0] c0, c1, cnt_ext;
  logic [HAW-1:0] pm1, par;
  logic           sel1, sd_end, sd_stop, push_stop;
  logic [EW-1:0]  sd_val;
  logic [HAW+1:0] sd_ch;
  logic [PW:0]    n_inc;

  assign wc = (gw_q == '0) ? 8'd1 : ((8'(gw_q) > WMax8) ? WMax8 : 8'(gw_q));
  assign hc = (gh_q == '0) ? 8'd1 : ((8'(gh_q) > HMax8) ? HMax8 : 8'(gh_q));

  assign qsx8   = 8'(query_i.start_x);
  assign qsy8   = 8'(query_i.start_y);
  assign qgx8   = 8'(query_i.goal_x);
  assign qgy8   = 8'(query_i.goal_y);
  assign q_off  = (qsx8 >= wc) || (qsy8 >= hc) || (qgx8 >= wc) || (qgy8 >= hc);
  assign q_same = (qsx8 == qgx8) && (qsy8 == qgy8);

  assign cx8 = 8'(cx_q);
  assign cy8 = 8'(cy_q);
  assign gx8 = 8'(gx_q);
  assign gy8 = 8'(gy_q);

  always_comb begin
    nx8 = cx8;
    ny8 = cy8;
    inb = 1'b0;
    case (dir_q)
      gbfs_pkg::DIR_UP: begin
        ny8 = cy8 - 8'd1;
        inb = cy8 != 8'd0;
      end
      gbfs_pkg::DIR_RIGHT: begin
        nx8 = cx8 + 8'd1;
        inb = nx8 < wc;
      end
      gbfs_pkg::DIR_DOWN: begin
        ny8 = cy8 + 8'd1;
        inb = ny8 < hc;
      end
      gbfs_pkg::DIR_LEFT: begin
        nx8 = cx8 - 8'd1;
        inb = cx8 != 8'd0;
      end
      default: begin
        inb = 1'b0;
      end
    endcase
  end

  assign naddr    = {ny8[CH-1:0], nx8[CW-1:0]};
  assign caddr    = {cy_q, cx_q};
  assign n_goal   = (nx8 == gx8) && (ny8 == gy8);
  assign ddx      = $signed({1'b0, gx8}) - $signed({1'b0, nx8});
  assign ddy      = $signed({1'b0, gy8}) - $signed({1'b0, ny8});
  assign sqx      = ddx * ddx;
  assign sqy      = ddy * ddy;
  assign dsum     = 19'(unsigned'(sqx)) + 19'(unsigned'(sqy));
  assign last_dir = dir_q == gbfs_pkg::DIR_LEFT;

  assign cnt_ext = (HAW + 2)'(cnt_q);
  assign c0      = {1'b0, idx_q, 1'b1};
  assign c1      = c0 + (HAW + 2)'(1);
  assign pm1     = idx_q - HAW'(1);
  assign par     = {1'b0, pm1[HAW-1:1]};
  assign sd_end  = c0 >= cnt_ext;
  assign sel1    = (c1 < cnt_ext) && (h_rd1 < h_rd0);
  assign sd_val  = sel1 ? h_rd1 : h_rd0;
  assign sd_ch   = sel1 ? c1 : c0;
  assign sd_stop = pend_q <= sd_val;
  assign push_stop = h_rd0 <= pend_q;

  assign at_start = (cx_q == sx_q) && (cy_q == sy_q);
  assign n_inc    = (PW + 1)'(n_q) + (PW + 1)'(1);
  assign path_end = at_start || (n_inc >= (PW + 1)'(MAX_PATH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbfs_pkg::S_IDLE: begin
        if (start && !q_off && !q_same) begin
          state_d = gbfs_pkg::S_CLEAR;
        end
      end
      gbfs_pkg::S_CLEAR: begin
        if (clr_q == '1) begin
          state_d = gbfs_pkg::S_INIT;
        end
      end
      gbfs_pkg::S_INIT: state_d = gbfs_pkg::S_POP;
      gbfs_pkg::S_POP: begin
        state_d = (cnt_q == '0) ? gbfs_pkg::S_IDLE : gbfs_pkg::S_POP_WAIT;
      end
      gbfs_pkg::S_POP_WAIT: state_d = gbfs_pkg::S_SD_RD;
      gbfs_pkg::S_SD_RD: begin
        state_d = sd_end ? gbfs_pkg::S_EXP_RD : gbfs_pkg::S_SD_CMP;
      end
      gbfs_pkg::S_SD_CMP: begin
        state_d = sd_stop ? gbfs_pkg::S_EXP_RD : gbfs_pkg::S_SD_RD;
      end
      gbfs_pkg::S_EXP_RD: begin
        if (inb) begin
          state_d = gbfs_pkg::S_EXP_CHK;
        end else if (last_dir) begin
          state_d = gbfs_pkg::S_POP;
        end
      end
      gbfs_pkg::S_EXP_CHK: begin
        if (t_rd[2]) begin
          state_d = last_dir ? gbfs_pkg::S_POP : gbfs_pkg::S_EXP_RD;
        end else if (n_goal) begin
          state_d = gbfs_pkg::S_WALK_EMIT;
        end else begin
          state_d = gbfs_pkg::S_PUSH_RD;
        end
      end
      gbfs_pkg::S_PUSH_RD: begin
        if (idx_q != '0) begin
          state_d = gbfs_pkg::S_PUSH_CMP;
        end else begin
          state_d = last_dir ? gbfs_pkg::S_POP : gbfs_pkg::S_EXP_RD;
        end
      end
      gbfs_pkg::S_PUSH_CMP: begin
        if (!push_stop) begin
          state_d = gbfs_pkg::S_PUSH_RD;
        end else begin
          state_d = last_dir ? gbfs_pkg::S_POP : gbfs_pkg::S_EXP_RD;
        end
      end
      gbfs_pkg::S_WALK_EMIT: begin
        state_d = path_end ? gbfs_pkg::S_IDLE : gbfs_pkg::S_WALK_STEP;
      end
      gbfs_pkg::S_WALK_STEP: state_d = gbfs_pkg::S_WALK_EMIT;
      default: state_d = gbfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sx_d        = sx_q;
    sy_d        = sy_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    n_d         = n_q;
    dir_d       = dir_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    h_we        = 1'b0;
    h_waddr     = idx_q;
    h_wdata     = pend_q;
    h_ra0       = '0;
    h_ra1       = '0;
    t_we        = 1'b0;
    t_waddr     = naddr;
    t_wdata     = {1'b1, dir_q};
    t_ra        = naddr;
    case (state_q)
      gbfs_pkg::S_IDLE: begin
        if (start) begin
          sx_d  = qsx8[CW-1:0];
          sy_d  = qsy8[CH-1:0];
          gx_d  = qgx8[CW-1:0];
          gy_d  = qgy8[CH-1:0];
          clr_d = '0;
          if (q_off) begin
            out_valid_d = 1'b1;
            out_d       = '{tile_x: 4'd0, tile_y: 4'd0, found: 1'b0, last_tile: 1'b1};
          end else if (q_same) begin
            out_valid_d = 1'b1;
            out_d       = '{tile_x: query_i.start_x, tile_y: query_i.start_y,
                            found: 1'b1, last_tile: 1'b1};
          end
        end
      end
      gbfs_pkg::S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_q;
        t_wdata = 3'd0;
        clr_d   = clr_q + TAW'(1);
      end
      gbfs_pkg::S_INIT: begin
        t_we    = 1'b1;
        t_waddr = {sy_q, sx_q};
        t_wdata = {1'b1, gbfs_pkg::DIR_UP};
        h_we    = 1'b1;
        h_waddr = '0;
        h_wdata = {DW'(0), SW'(0), sy_q, sx_q};
        cnt_d   = CNTW'(1);
        seq_d   = SW'(1);
      end
      gbfs_pkg::S_POP: begin
        h_ra0 = '0;
        h_ra1 = HAW'(cnt_q - CNTW'(1));
        if (cnt_q == '0) begin
          out_valid_d = 1'b1;
          out_d       = '{tile_x: 4'd0, tile_y: 4'd0, found: 1'b0, last_tile: 1'b1};
        end
      end
      gbfs_pkg::S_POP_WAIT: begin
        cx_d   = h_rd0[CW-1:0];
        cy_d   = h_rd0[TAW-1:CW];
        pend_d = h_rd1;
        cnt_d  = cnt_q - CNTW'(1);
        idx_d  = '0;
      end
      gbfs_pkg::S_SD_RD: begin
        h_ra0 = c0[HAW-1:0];
        h_ra1 = c1[HAW-1:0];
        if (sd_end) begin
          h_we  = 1'b1;
          dir_d = gbfs_pkg::DIR_UP;
        end
      end
      gbfs_pkg::S_SD_CMP: begin
        h_we = 1'b1;
        if (sd_stop) begin
          dir_d = gbfs_pkg::DIR_UP;
        end else begin
          h_wdata = sd_val;
          idx_d   = sd_ch[HAW-1:0];
        end
      end
      gbfs_pkg::S_EXP_RD: begin
        if (!inb && !last_dir) begin
          dir_d = gbfs_pkg::dir_e'(dir_q + 2'd1);
        end
      end
      gbfs_pkg::S_EXP_CHK: begin
        if (t_rd[2]) begin
          if (!last_dir) begin
            dir_d = gbfs_pkg::dir_e'(dir_q + 2'd1);
          end
        end else begin
          t_we = 1'b1;
          if (n_goal) begin
            cx_d = gx_q;
            cy_d = gy_q;
            n_d  = '0;
          end else begin
            pend_d = {dsum[DW-1:0], seq_q, naddr};
            seq_d  = seq_q + SW'(1);
            idx_d  = cnt_q[HAW-1:0];
            cnt_d  = cnt_q + CNTW'(1);
          end
        end
      end
      gbfs_pkg::S_PUSH_RD: begin
        h_ra0 = par;
        if (idx_q == '0) begin
          h_we = 1'b1;
          if (!last_dir) begin
            dir_d = gbfs_pkg::dir_e'(dir_q + 2'd1);
          end
        end
      end
      gbfs_pkg::S_PUSH_CMP: begin
        h_we = 1'b1;
        if (push_stop) begin
          if (!last_dir) begin
            dir_d = gbfs_pkg::dir_e'(dir_q + 2'd1);
          end
        end else begin
          h_wdata = h_rd0;
          idx_d   = par;
        end
      end
      gbfs_pkg::S_WALK_EMIT: begin
        out_valid_d = 1'b1;
        out_d       = '{tile_x: cx8[3:0], tile_y: cy8[3:0], found: 1'b1,
                        last_tile: path_end};
        t_ra        = caddr;
        n_d         = n_inc[PW-1:0];
      end
      gbfs_pkg::S_WALK_STEP: begin
        case (gbfs_pkg::dir_e'(t_rd[1:0]))
          gbfs_pkg::DIR_UP:    cy_d = cy_q + CH'(1);
          gbfs_pkg::DIR_RIGHT: cx_d = cx_q - CW'(1);
          gbfs_pkg::DIR_DOWN:  cy_d = cy_q - CH'(1);
          gbfs_pkg::DIR_LEFT:  cx_d = cx_q + CW'(1);
          default:             cx_d = cx_q;
        endcase
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbfs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      gw_q        <= gbfs_pkg::GridWidthReset;
      gh_q        <= gbfs_pkg::GridHeightReset;
      cnt_q       <= '0;
      seq_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      seq_q       <= seq_d;
      if (cfg_we_i && cfg_addr_i == gbfs_pkg::CFG_GRID_WIDTH) begin
        gw_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_addr_i == gbfs_pkg::CFG_GRID_HEIGHT) begin
        gh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    clr_q  <= clr_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
    n_q    <= n_d;
    dir_q  <= dir_d;
    out_q  <= out_d;
  end

  gbfs_heap_ram #(
    .AW(HAW),
    .DW(EW)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr0_i(h_ra0),
    .raddr1_i(h_ra1),
    .rdata0_o(h_rd0),
    .rdata1_o(h_rd1)
  );

  gbfs_tile_ram #(
    .AW(TAW),
    .DW(3)
  ) u_tile_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .raddr_i(t_ra),
    .rdata_o(t_rd)
  );

  assign busy           = state_q != gbfs_pkg::S_IDLE;
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(NTILES))
    else $error("frontier count above the number of tiles");

  a_walk_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gbfs_pkg::S_WALK_STEP |-> t_rd[2])
    else $error("path walk reached a tile that was never discovered");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.found |-> result_o.last_tile)
    else $error("a no-path result is not the final transfer");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && result_o.last_tile)
    else $error("busy dropped without a final result transfer");
`endif

endmodule

@@ bench/tb_grid_best_first_path_search.sv @@
// Testbench for the grid best-first path search block.
// Drives start/goal queries, predicts each path tile with its own search model and checks it.
// Depends on gbfs_pkg and the grid_best_first_path_search RTL.
`timescale 1ns / 100ps

module tb_grid_best_first_path_search;

  localparam int GridMax     = 16;
  localparam int PathMax     = 64;
  localparam int NumTiles    = GridMax * GridMax;
  localparam int IdleLimit   = 20000;
  localparam int NumRandom   = 120;
  localparam int NumDirected = 14;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  gbfs_pkg::query_t              query_i = '0;
  logic                          result_valid_o;
  gbfs_pkg::result_t             result_o;
  logic                          cfg_we_i = 1'b0;
  logic [gbfs_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [gbfs_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  grid_best_first_path_search DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .query_i(query_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  gbfs_pkg::result_t path_tiles_q[$];
  logic [4:0]        width_reg = gbfs_pkg::GridWidthReset;
  logic [4:0]        height_reg = gbfs_pkg::GridHeightReset;
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                timed_out = 1'b0;

  bit                seen_tile[NumTiles];
  gbfs_pkg::dir_e    came_from[NumTiles];
  logic [31:0]       frontier_key[$];

  function automatic int clamp_dim(logic [4:0] v);
    if (v == 0) return 1;
    if (v > GridMax) return GridMax;
    return v;
  endfunction

  function automatic gbfs_pkg::result_t make_tile(int x, int y, bit fnd, bit lst);
    gbfs_pkg::result_t r;
    r.tile_x = x[3:0];
    r.tile_y = y[3:0];
    r.found = fnd;
    r.last_tile = lst;
    return r;
  endfunction

  function automatic void expect_tile(gbfs_pkg::result_t r);
    path_tiles_q.insert(path_tiles_q.size(), r);
  endfunction

  // Frontier entries are {distance, sequence, tile}; the smallest key wins, so equal
  // distances go to the earliest insertion.
  function automatic int pop_nearest();
    int best;
    logic [31:0] e;
    best = 0;
    foreach (frontier_key[i]) if (frontier_key[i] < frontier_key[best]) best = i;
    e = frontier_key[best];
    frontier_key.delete(best);
    return e[7:0];
  endfunction

  task automatic predict_path(gbfs_pkg::query_t q);
    int w, h, sx, sy, gx, gy, x, y, nx, ny, nt, t, n, seq, dd;
    int dxs[4], dys[4];
    dxs = '{0, 1, 0, -1};
    dys = '{-1, 0, 1, 0};
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    sx = q.start_x; sy = q.start_y; gx = q.goal_x; gy = q.goal_y;
    if (sx >= w || sy >= h || gx >= w || gy >= h) begin
      expect_tile(make_tile(0, 0, 1'b0, 1'b1));
      return;
    end
    if (sx == gx && sy == gy) begin
      expect_tile(make_tile(sx, sy, 1'b1, 1'b1));
      return;
    end
    foreach (seen_tile[i]) seen_tile[i] = 1'b0;
    frontier_key.delete();
    seq = 0;
    seen_tile[sy * GridMax + sx] = 1'b1;
    frontier_key.insert(frontier_key.size(), {16'd0, seq[7:0], 8'(sy * GridMax + sx)});
    seq++;
    while (frontier_key.size() > 0) begin
      t = pop_nearest();
      x = t % GridMax;
      y = t / GridMax;
      for (int d = 0; d < 4; d++) begin
        nx = x + dxs[d];
        ny = y + dys[d];
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        nt = ny * GridMax + nx;
        if (seen_tile[nt]) continue;
        seen_tile[nt] = 1'b1;
        came_from[nt] = gbfs_pkg::dir_e'(d);
        dd = (gx - nx) * (gx - nx) + (gy - ny) * (gy - ny);
        frontier_key.insert(frontier_key.size(), {dd[15:0], seq[7:0], nt[7:0]});
        seq++;
        if (nx == gx && ny == gy) begin
          x = gx; y = gy; n = 0;
          forever begin
            n++;
            if ((x == sx && y == sy) || n >= PathMax) begin
              expect_tile(make_tile(x, y, 1'b1, 1'b1));
              break;
            end
            expect_tile(make_tile(x, y, 1'b1, 1'b0));
            nt = y * GridMax + x;
            x -= dxs[came_from[nt]];
            y -= dys[came_from[nt]];
          end
          return;
        end
      end
    end
    expect_tile(make_tile(0, 0, 1'b0, 1'b1));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (path_tiles_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", result_o);
      end else begin
        gbfs_pkg::result_t exp_r;
        exp_r = path_tiles_q.pop_front();
        if (result_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) timed_out <= 1'b1;
  end

  task automatic write_reg(logic [gbfs_pkg::CfgAddrW-1:0] idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gbfs_pkg::CFG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk_i);
  endtask

  // Every query has a result, so an empty queue plus busy low means the block is idle.
  task automatic wait_drained();
    while (path_tiles_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_query(gbfs_pkg::query_t q, bit hold);
    start <= 1'b1;
    query_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_path(q);
    if (!hold) start <= 1'b0;
  endtask

  typedef struct {
    logic [4:0]       w, h;
    gbfs_pkg::query_t q;
    bit               typed;
    gbfs_pkg::result_t first;
  } directed_row_t;

  directed_row_t directed_rows[NumDirected] = '{
    '{5'd16, 5'd16, '{4'd0, 4'd0, 4'd0, 4'd0}, 1'b1, '{4'd0, 4'd0, 1'b1, 1'b1}},
    '{5'd16, 5'd16, '{4'd15, 4'd15, 4'd15, 4'd15}, 1'b1, '{4'd15, 4'd15, 1'b1, 1'b1}},
    '{5'd16, 5'd16, '{4'd0, 4'd0, 4'd15, 4'd15}, 1'b1, '{4'd15, 4'd15, 1'b1, 1'b0}},
    '{5'd16, 5'd16, '{4'd15, 4'd15, 4'd0, 4'd0}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd16, 5'd16, '{4'd15, 4'd0, 4'd0, 4'd15}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd16, 5'd16, '{4'd5, 4'd5, 4'd6, 4'd5}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd4, 5'd4, '{4'd4, 4'd0, 4'd1, 4'd1}, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b1}},
    '{5'd4, 5'd4, '{4'd0, 4'd0, 4'd1, 4'd4}, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b1}},
    '{5'd4, 5'd4, '{4'd3, 4'd3, 4'd0, 4'd0}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd0, 5'd0, '{4'd0, 4'd0, 4'd0, 4'd0}, 1'b1, '{4'd0, 4'd0, 1'b1, 1'b1}},
    '{5'd0, 5'd0, '{4'd1, 4'd0, 4'd0, 4'd0}, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b1}},
    '{5'd31, 5'd1, '{4'd0, 4'd0, 4'd15, 4'd0}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd1, 5'd31, '{4'd0, 4'd15, 4'd0, 4'd0}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{5'd17, 5'd20, '{4'd3, 4'd9, 4'd12, 4'd2}, 1'b0, '{4'd0, 4'd0, 1'b0, 1'b0}}
  };

  initial begin
    gbfs_pkg::query_t q;
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].w != width_reg)
        write_reg(gbfs_pkg::CFG_GRID_WIDTH, directed_rows[i].w);
      if (directed_rows[i].h != height_reg)
        write_reg(gbfs_pkg::CFG_GRID_HEIGHT, directed_rows[i].h);
      send_query(directed_rows[i].q, 1'b0);
      if (directed_rows[i].typed && path_tiles_q[0] !== directed_rows[i].first) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Row %0d: expected first tile %p, predicted %p", i,
                   directed_rows[i].first, path_tiles_q[0]);
      end
      wait_drained();
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(gbfs_pkg::CFG_GRID_WIDTH, 5'd16);
          write_reg(gbfs_pkg::CFG_GRID_HEIGHT, 5'd16);
        end
        1: begin
          write_reg(gbfs_pkg::CFG_GRID_WIDTH, 5'd1);
          write_reg(gbfs_pkg::CFG_GRID_HEIGHT, 5'd16);
        end
        2: begin
          write_reg(gbfs_pkg::CFG_GRID_WIDTH, 5'($urandom_range(0, 31)));
          write_reg(gbfs_pkg::CFG_GRID_HEIGHT, 5'($urandom_range(0, 31)));
        end
        default: begin
          write_reg(gbfs_pkg::CFG_GRID_WIDTH, 5'($urandom_range(2, 8)));
          write_reg(gbfs_pkg::CFG_GRID_HEIGHT, 5'($urandom_range(2, 8)));
        end
      endcase
      for (int n = 0; n < NumRandom / 4; ) begin
        burst = $urandom_range(1, 5);
        for (int b = 0; b < burst && n < NumRandom / 4; b++, n++) begin
          q = gbfs_pkg::query_t'(16'($urandom));
          // Mostly on-grid queries so the search itself is exercised.
          if ($urandom_range(0, 9) != 0) begin
            q.start_x = 4'($urandom_range(0, clamp_dim(width_reg) - 1));
            q.goal_x  = 4'($urandom_range(0, clamp_dim(width_reg) - 1));
            q.start_y = 4'($urandom_range(0, clamp_dim(height_reg) - 1));
            q.goal_y  = 4'($urandom_range(0, clamp_dim(height_reg) - 1));
          end
          send_query(q, (b + 1 < burst) && (n + 1 < NumRandom / 4));
        end
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && path_tiles_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ grid_best_first_path_search.f @@
rtl/gbfs_pkg.sv
rtl/gbfs_heap_ram.sv
rtl/gbfs_tile_ram.sv
rtl/grid_best_first_path_search.sv
bench/tb_grid_best_first_path_search.sv
